### sv/newton_square_root_assert.svh
// assertion macros used by the newton square root queue
`ifndef NEWTON_SQUARE_ROOT_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_ASSERT_SVH

// property must hold at every rising clock edge out of reset
`define NSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen at a rising clock edge out of reset
`define NSR_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### sv/nsr_pkg.sv
// types and constants of the newton square root block
`timescale 1ns / 1ps

package nsr_pkg;

   localparam int unsigned ITERATIONS_DEFAULT = 10;

   localparam int X_W    = 32;          // signed q16.16 operand
   localparam int EST_W  = 31;          // non-negative estimate, unsigned q15.16
   localparam int FRAC_W = 16;
   localparam int SQ_W   = 2 * EST_W;   // exact square, q30.32
   localparam int DIV_W  = EST_W + 1;   // divisor 2*estimate
   localparam int QUOT_W = 34;          // quotient magnitude bits
   localparam int REM_W  = SQ_W;        // remainder magnitude bits

   localparam logic [EST_W-1:0] ONE_TENTH = EST_W'(6554);
   localparam logic [EST_W-1:0] EST_MAX   = {EST_W{1'b1}};

   localparam int QUEUE_DEPTH = 4;

   // one classified operand waiting for the iteration pipe
   typedef struct packed {
      logic             zero;   // operand at or below zero
      logic [EST_W-1:0] x;
   } item_type;

   // item state handed from one newton step to the next
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [EST_W-1:0] x;
      logic [EST_W-1:0] est;
   } est_type;

endpackage

### sv/nsr_front.sv
// front end: takes operands and classifies them for the queue
`timescale 1ns / 1ps

module nsr_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [nsr_pkg::X_W-1:0]  req_x_value,
   input  logic                     queue_full,
   output logic                     push,
   output nsr_pkg::item_type        push_item
);
   import nsr_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // zero or negative operand gives a zero root
   always_comb begin
      push_item.zero = req_x_value[X_W-1] || (req_x_value == '0);
      push_item.x    = req_x_value[EST_W-1:0];
   end

endmodule

### sv/nsr_queue.sv
// small queue between the front end and the iteration pipe
`timescale 1ns / 1ps
`include "newton_square_root_assert.svh"

module nsr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nsr_pkg::item_type push_item,
   input  logic              pop,
   output nsr_pkg::item_type head_item,
   output logic              empty,
   output logic              full
);
   import nsr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ff];
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));

   `NSR_ASSERT(a_push_room, push |-> !full, "push into a full queue")
   `NSR_ASSERT(a_pop_data, pop |-> !empty, "pop from an empty queue")
   `NSR_ASSERT(a_count_up, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "count lost a push")
   `NSR_NEVER(a_count_range, count_ff > CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

### sv/nsr_iter.sv
// one pipelined newton step: square, residual, restoring divide, update
`timescale 1ns / 1ps

module nsr_iter (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  nsr_pkg::est_type in_item,
   output nsr_pkg::est_type out_item
);
   import nsr_pkg::*;

   localparam int DIV_STAGES = QUOT_W;
   localparam int SH_W       = DIV_W + QUOT_W;

   // stage 1: estimate guard and square
   logic             v1_ff, v1_in;
   logic             z1_ff;
   logic [EST_W-1:0] x1_ff;
   logic [EST_W-1:0] e1_ff, e1_in;
   logic [SQ_W-1:0]  sq1_ff, sq1_in;

   always_comb begin
      v1_in  = in_item.valid;
      e1_in  = (in_item.est == '0) ? ONE_TENTH : in_item.est;
      sq1_in = SQ_W'(e1_in) * SQ_W'(e1_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z1_ff  <= in_item.zero;
         x1_ff  <= in_item.x;
         e1_ff  <= e1_in;
         sq1_ff <= sq1_in;
      end
   end

   // divider stage registers, index 0 holds the residual magnitude
   logic             v_ff   [DIV_STAGES+1];
   logic             z_ff   [DIV_STAGES+1];
   logic             neg_ff [DIV_STAGES+1];
   logic [EST_W-1:0] x_ff   [DIV_STAGES+1];
   logic [EST_W-1:0] e_ff   [DIV_STAGES+1];
   logic [DIV_W-1:0] d_ff   [DIV_STAGES+1];
   logic [REM_W-1:0] rem_ff [DIV_STAGES+1];
   logic [QUOT_W-1:0] q_ff  [DIV_STAGES+1];

   // stage 2: residual x*2^16 - est^2 as sign and magnitude
   logic [SQ_W-1:0] xw;
   logic            neg2_in;
   logic [REM_W-1:0] mag2_in;

   always_comb begin
      xw      = SQ_W'({x1_ff, FRAC_W'(0)});
      neg2_in = sq1_ff > xw;
      mag2_in = neg2_in ? (sq1_ff - xw) : (xw - sq1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[0]   <= z1_ff;
         neg_ff[0] <= neg2_in;
         x_ff[0]   <= x1_ff;
         e_ff[0]   <= e1_ff;
         d_ff[0]   <= {e1_ff, 1'b0};
         rem_ff[0] <= mag2_in;
         q_ff[0]   <= '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      localparam int BIT = DIV_STAGES - 1 - g;
      logic [SH_W-1:0]   div_sh;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [QUOT_W-1:0] q_in;

      always_comb begin
         div_sh = SH_W'(d_ff[g]) << BIT;
         ge     = SH_W'(rem_ff[g]) >= div_sh;
         rem_in = ge ? (rem_ff[g] - div_sh[REM_W-1:0]) : rem_ff[g];
         q_in   = {q_ff[g][QUOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (enable) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            z_ff[g+1]   <= z_ff[g];
            neg_ff[g+1] <= neg_ff[g];
            x_ff[g+1]   <= x_ff[g];
            e_ff[g+1]   <= e_ff[g];
            d_ff[g+1]   <= d_ff[g];
            rem_ff[g+1] <= rem_in;
            q_ff[g+1]   <= q_in;
         end
      end
   end

   // update: est +/- quotient, clamped to the estimate range
   logic [QUOT_W:0]  sum;
   logic [EST_W-1:0] est_in;
   logic             vo_ff;
   logic             zo_ff;
   logic [EST_W-1:0] xo_ff;
   logic [EST_W-1:0] est_ff;

   always_comb begin
      sum = (QUOT_W+1)'(e_ff[DIV_STAGES]) + (QUOT_W+1)'(q_ff[DIV_STAGES]);
      if (neg_ff[DIV_STAGES]) begin
         if (q_ff[DIV_STAGES] >= QUOT_W'(e_ff[DIV_STAGES])) begin
            est_in = '0;
         end else begin
            est_in = e_ff[DIV_STAGES] - q_ff[DIV_STAGES][EST_W-1:0];
         end
      end else if (sum > (QUOT_W+1)'(EST_MAX)) begin
         est_in = EST_MAX;
      end else begin
         est_in = sum[EST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (enable) begin
         vo_ff <= v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zo_ff  <= z_ff[DIV_STAGES];
         xo_ff  <= x_ff[DIV_STAGES];
         est_ff <= est_in;
      end
   end

   always_comb begin
      out_item.valid = vo_ff;
      out_item.zero  = zo_ff;
      out_item.x     = xo_ff;
      out_item.est   = est_ff;
   end

endmodule

### sv/newton_square_root.sv
// top level of the pipelined newton square root
//
//   channel  direction  ports                              payload
//   req      in         req_valid  req_stall  req_x_value  signed q16.16 operand
//   rsp      out        rsp_valid  rsp_stall  rsp_root     unsigned q15.16 root
//
// one operand per cycle enters while the queue has room (req_stall low)
// each newton step spends one stage per quotient bit in its 34-stage restoring divider
// reset clears the queue pointers and all pipe valid bits, payload is not reset
// rsp_stall with rsp_valid freezes the whole iteration pipe; the queue then fills and raises req_stall
`timescale 1ns / 1ps

module newton_square_root #(
   parameter int unsigned ITERATIONS = nsr_pkg::ITERATIONS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [nsr_pkg::X_W-1:0]    req_x_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [nsr_pkg::EST_W-1:0]  rsp_root
);
   import nsr_pkg::*;

   logic     queue_full;
   logic     queue_empty;
   logic     push;
   logic     pop;
   logic     enable;
   item_type push_item;
   item_type head_item;
   est_type  link [ITERATIONS+1];

   // front end: classify and transfer into the queue
   nsr_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_x_value (req_x_value),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   nsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // pipe moves unless a finished result waits on a stalled consumer
   assign enable = !(rsp_valid && rsp_stall);
   assign pop    = enable && !queue_empty;

   // estimate starts equal to the operand
   always_comb begin
      link[0].valid = !queue_empty;
      link[0].zero  = head_item.zero;
      link[0].x     = head_item.x;
      link[0].est   = head_item.x;
   end

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
      nsr_iter u_iter (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_item  (link[i]),
         .out_item (link[i+1])
      );
   end

   // zero or negative operands report zero
   assign rsp_valid = link[ITERATIONS].valid;
   assign rsp_root  = link[ITERATIONS].zero ? '0 : link[ITERATIONS].est;

endmodule
